>>> rtl/miller_rabin_prime_test_64_unit_assert.svh
// assertion macros for the port-level checker
`ifndef MILLER_RABIN_PRIME_TEST_64_UNIT_ASSERT_SVH
`define MILLER_RABIN_PRIME_TEST_64_UNIT_ASSERT_SVH

// implication in the same cycle, off during reset
`define MRT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication in the next cycle, off during reset
`define MRT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// implication in the next cycle, checked during reset too
`define MRT_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mrt_pkg.sv
// constants, tables and types of the primality test unit
`default_nettype none
package mrt_pkg;
   localparam int WIDTH       = 64;
   localparam int CAND_W      = 64;
   localparam int SMALL_COUNT = 10;
   localparam int BASE_COUNT  = 7;
   localparam int CNT_W       = $clog2(WIDTH);
   localparam int IDX_W       = 4;
   localparam int BIDX_W      = $clog2(BASE_COUNT);

   localparam logic [WIDTH-1:0] SMALL_PRIMES [SMALL_COUNT] = '{
      WIDTH'(2), WIDTH'(3), WIDTH'(5), WIDTH'(7), WIDTH'(11),
      WIDTH'(13), WIDTH'(17), WIDTH'(19), WIDTH'(23), WIDTH'(29)
   };

   localparam logic [WIDTH-1:0] MR_BASES [BASE_COUNT] = '{
      WIDTH'(2), WIDTH'(325), WIDTH'(9375), WIDTH'(28178),
      WIDTH'(450775), WIDTH'(9780504), WIDTH'(1795265022)
   };

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SMALL = 9'b000000010,
      ST_SPLIT = 9'b000000100,
      ST_BASE  = 9'b000001000,
      ST_PMUL  = 9'b000010000,
      ST_PSQR  = 9'b000100000,
      ST_CHK   = 9'b001000000,
      ST_SQR   = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   typedef struct packed {
      logic start;
      logic done;
   } unit_ctl_type;
endpackage
`default_nettype wire

>>> rtl/mrt_if.sv
// request and response channel interfaces
`default_nettype none
interface mrt_req_if;
   logic                      valid;
   logic                      ready;
   logic [mrt_pkg::CAND_W-1:0] candidate;
   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

interface mrt_rsp_if;
   logic valid;
   logic ready;
   logic prime_flag;
   modport source (output valid, output prime_flag, input ready);
   modport sink   (input valid, input prime_flag, output ready);
endinterface
`default_nettype wire

>>> rtl/mrt_rem.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
`default_nettype none
module mrt_rem (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [mrt_pkg::WIDTH-1:0] dividend,
   input  wire logic [mrt_pkg::WIDTH-1:0] divisor,
   output logic                           done,
   output logic [mrt_pkg::WIDTH-1:0]      remainder
);
   import mrt_pkg::*;

   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[WIDTH-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         rem_in = trial[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

>>> rtl/mrt_modmul.sv
// bit-serial shift-add modular multiplier, double then add per multiplier bit
`default_nettype none
module mrt_modmul (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mrt_pkg::unit_ctl_type     ctl_in,
   input  wire logic [mrt_pkg::WIDTH-1:0] op_x,
   input  wire logic [mrt_pkg::WIDTH-1:0] op_y,
   input  wire logic [mrt_pkg::WIDTH-1:0] modulus,
   output mrt_pkg::unit_ctl_type          ctl_out,
   output logic [mrt_pkg::WIDTH-1:0]      product
);
   import mrt_pkg::*;

   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] x_ff, x_in;
   logic [WIDTH-1:0] y_ff, y_in;
   logic [WIDTH-1:0] m_ff, m_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             add_phase_ff, add_phase_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH-1:0] addend;
   logic [WIDTH:0]   sum;

   // one shared adder: doubles in the first phase, adds x in the second
   always_comb begin
      addend = add_phase_ff ? x_ff : acc_ff;
      sum    = {1'b0, acc_ff} + {1'b0, addend};
      if (sum >= {1'b0, m_ff}) begin
         sum = sum - {1'b0, m_ff};
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      m_in         = m_ff;
      cnt_in       = cnt_ff;
      add_phase_in = add_phase_ff;
      busy_in      = busy_ff;
      done_in      = 1'b0;
      if (ctl_in.start) begin
         acc_in       = '0;
         x_in         = op_x;
         y_in         = op_y;
         m_in         = modulus;
         cnt_in       = '0;
         add_phase_in = 1'b0;
         busy_in      = 1'b1;
      end else if (busy_ff) begin
         if (!add_phase_ff) begin
            acc_in       = sum[WIDTH-1:0];
            add_phase_in = 1'b1;
         end else begin
            if (y_ff[WIDTH-1]) begin
               acc_in = sum[WIDTH-1:0];
            end
            y_in         = {y_ff[WIDTH-2:0], 1'b0};
            add_phase_in = 1'b0;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(WIDTH - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      m_ff         <= m_in;
      cnt_ff       <= cnt_in;
      add_phase_ff <= add_phase_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign ctl_out.start = busy_ff;
   assign ctl_out.done  = done_ff;
   assign product       = acc_ff;
endmodule
`default_nettype wire

>>> rtl/miller_rabin_prime_test_64_unit.sv
// top level: deterministic 64-bit miller-rabin primality test sequencer
//
// usage
//  - req_chan carries one 64-bit candidate per transfer (valid/ready)
//  - rsp_chan returns one prime_flag per candidate, in order
//  - one candidate is worked on at a time; req_chan.ready is high only
//    while the sequencer is idle
//  - trial division by ten small primes runs on the serial remainder
//    unit, as does each base reduction; each modular multiply runs on
//    the shared shift-add multiplier (one double step and one add step
//    per multiplier bit)
//  - worst case about 7 bases * ~128 multiplies; values below two are
//    answered without any test, and a small-prime divisor ends it early
//  - a finished flag sits in an output register, so a new candidate is
//    taken while the previous flag still waits on a stalled receiver;
//    the sequencer holds its next flag until that register frees up
//  - synchronous reset returns to idle and drops rsp_chan.valid
`default_nettype none
module miller_rabin_prime_test_64_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   mrt_req_if.sink    req_chan,
   mrt_rsp_if.source  rsp_chan
);
   import mrt_pkg::*;

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] n_ff, n_in;
   logic [WIDTH-1:0] d_ff, d_in;
   logic [CNT_W-1:0] s_ff, s_in;
   logic [CNT_W-1:0] rcnt_ff, rcnt_in;
   logic [WIDTH-1:0] e_ff, e_in;
   logic [WIDTH-1:0] res_ff, res_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             launched_ff, launched_in;
   logic             flag_ff, flag_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_flag_ff, rsp_flag_in;

   logic [WIDTH-1:0] nm1;
   logic [WIDTH-1:0] cand;
   logic             req_xfer;

   // shared remainder unit
   logic             rem_start;
   logic [WIDTH-1:0] rem_dividend;
   logic [WIDTH-1:0] rem_divisor;
   logic             rem_done;
   logic [WIDTH-1:0] rem_value;

   // shared modular multiplier
   unit_ctl_type     mul_req, mul_stat;
   logic [WIDTH-1:0] mul_x, mul_y, mul_p;

   mrt_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_dividend),
      .divisor   (rem_divisor),
      .done      (rem_done),
      .remainder (rem_value)
   );

   mrt_modmul u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctl_in  (mul_req),
      .op_x    (mul_x),
      .op_y    (mul_y),
      .modulus (n_ff),
      .ctl_out (mul_stat),
      .product (mul_p)
   );

   assign nm1      = n_ff - WIDTH'(1);
   assign cand     = req_chan.candidate[WIDTH-1:0];
   assign req_xfer = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      s_in         = s_ff;
      rcnt_in      = rcnt_ff;
      e_in         = e_ff;
      res_in       = res_ff;
      b_in         = b_ff;
      idx_in       = idx_ff;
      launched_in  = launched_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_flag_in  = rsp_flag_ff;

      rem_start     = 1'b0;
      rem_dividend  = n_ff;
      rem_divisor   = SMALL_PRIMES[idx_ff];
      mul_req.start = 1'b0;
      mul_req.done  = 1'b0;
      mul_x         = res_ff;
      mul_y         = b_ff;

      // output register drains independently of the sequencer
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               n_in = cand;
               idx_in = '0;
               launched_in = 1'b0;
               if (cand < WIDTH'(2)) begin
                  flag_in  = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_SMALL;
               end
            end
         end

         // trial division by the small primes
         ST_SMALL: begin
            if (!launched_ff) begin
               rem_start   = 1'b1;
               launched_in = 1'b1;
            end else if (rem_done) begin
               launched_in = 1'b0;
               if (rem_value == '0) begin
                  flag_in  = (n_ff == SMALL_PRIMES[idx_ff]);
                  state_in = ST_OUT;
               end else if (idx_ff == IDX_W'(SMALL_COUNT - 1)) begin
                  d_in     = nm1;
                  s_in     = '0;
                  state_in = ST_SPLIT;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         // n-1 = d * 2^s, one shift per cycle
         ST_SPLIT: begin
            if (!d_ff[0]) begin
               d_in = {1'b0, d_ff[WIDTH-1:1]};
               s_in = s_ff + 1'b1;
            end else begin
               idx_in   = '0;
               state_in = ST_BASE;
            end
         end

         // reduce the next base mod n, skip it when it vanishes
         ST_BASE: begin
            rem_dividend = MR_BASES[idx_ff[BIDX_W-1:0]];
            rem_divisor  = n_ff;
            if (idx_ff == IDX_W'(BASE_COUNT)) begin
               flag_in  = 1'b1;
               state_in = ST_OUT;
            end else if (!launched_ff) begin
               rem_start   = 1'b1;
               launched_in = 1'b1;
            end else if (rem_done) begin
               launched_in = 1'b0;
               if (rem_value == '0) begin
                  idx_in = idx_ff + 1'b1;
               end else begin
                  b_in     = rem_value;
                  res_in   = WIDTH'(1);
                  e_in     = d_ff;
                  state_in = ST_PMUL;
               end
            end
         end

         // exponent bit set: res = res * b
         ST_PMUL: begin
            if (e_ff == '0) begin
               state_in = ST_CHK;
            end else if (!e_ff[0]) begin
               state_in = ST_PSQR;
            end else if (!launched_ff) begin
               mul_req.start = 1'b1;
               launched_in   = 1'b1;
            end else if (mul_stat.done) begin
               launched_in = 1'b0;
               res_in      = mul_p;
               state_in    = ST_PSQR;
            end
         end

         // b = b * b, next exponent bit; last square is not needed
         ST_PSQR: begin
            mul_x = b_ff;
            if (e_ff[WIDTH-1:1] == '0) begin
               e_in     = '0;
               state_in = ST_PMUL;
            end else if (!launched_ff) begin
               mul_req.start = 1'b1;
               launched_in   = 1'b1;
            end else if (mul_stat.done) begin
               launched_in = 1'b0;
               b_in        = mul_p;
               e_in        = {1'b0, e_ff[WIDTH-1:1]};
               state_in    = ST_PMUL;
            end
         end

         ST_CHK: begin
            if (res_ff == WIDTH'(1) || res_ff == nm1) begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_BASE;
            end else begin
               rcnt_in  = CNT_W'(1);
               state_in = ST_SQR;
            end
         end

         // repeated squaring looking for n-1
         ST_SQR: begin
            mul_y = res_ff;
            if (rcnt_ff >= s_ff) begin
               flag_in  = 1'b0;
               state_in = ST_OUT;
            end else if (!launched_ff) begin
               mul_req.start = 1'b1;
               launched_in   = 1'b1;
            end else if (mul_stat.done) begin
               launched_in = 1'b0;
               res_in      = mul_p;
               if (mul_p == nm1) begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_BASE;
               end else begin
                  rcnt_in = rcnt_ff + 1'b1;
               end
            end
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = flag_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      d_ff        <= d_in;
      s_ff        <= s_in;
      rcnt_ff     <= rcnt_in;
      e_ff        <= e_in;
      res_ff      <= res_in;
      b_ff        <= b_in;
      idx_ff      <= idx_in;
      flag_ff     <= flag_in;
      rsp_flag_ff <= rsp_flag_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.prime_flag = rsp_flag_ff;
endmodule
`default_nettype wire

>>> rtl/mrt_checker.sv
// port-level checker for the primality test unit and its bind
`default_nettype none
`include "miller_rabin_prime_test_64_unit_assert.svh"
module mrt_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_prime_flag
);
   `MRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_prime_flag), "stalled response changed")
   `MRT_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready, "ready stayed high after a request transfer")
   `MRT_ASSERT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid, "response valid after reset")
endmodule

bind miller_rabin_prime_test_64_unit mrt_checker u_mrt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_prime_flag (rsp_chan.prime_flag)
);
`default_nettype wire
